// ===== design/gn2_pkg.sv =====
// shared constants, types and a helper function for the gradient noise pipeline
package gn2_pkg;

    // hash multipliers
    localparam logic [31:0] HASH_K0 = 32'd3284157443;
    localparam logic [31:0] HASH_K1 = 32'd1911520717;
    localparam logic [31:0] HASH_K2 = 32'd2048419325;

    // quarter-wave sine polynomial, q14 / q15
    localparam logic [15:0] SIN_A    = 16'd21024;
    localparam logic [11:0] SIN_B    = 12'd2320;
    localparam logic [15:0] SIN_C    = 16'd51472;
    localparam logic [14:0] QTR_Z    = 15'd16384;
    localparam logic [16:0] SIN_MAX  = 17'd32767;
    localparam logic [15:0] TURN_QTR = 16'h4000;

    // smoothstep 3.0 in q16
    localparam logic [17:0] WT_THREE = 18'd196608;

    // corner dot product in q15, with headroom
    typedef logic signed [17:0] t_dot;
    // smoothstep weight in q16
    typedef logic [17:0] t_wt;

    function automatic logic [31:0] rotl16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

endpackage

// ===== design/gradient_noise_2d.sv =====
// top level of the 2d gradient noise pipeline
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------
//  point    | in  | i_valid / o_stall  | i_x_coord, i_y_coord (q16.16)
//  noise    | out | o_valid / i_stall  | o_noise_value (signed q1.15)
//
//  one item per cycle sustained while the pipe is not halted; 13 register
//  stages, and o_valid is the valid bit of the last of them
//  stages: input stage, 8-stage corner lanes (3 hash multiplies, 4-stage
//  sine polynomial, dot product), 4-stage blend ending in the output register
//  the whole pipe advances together; it halts only while o_valid is high and
//  i_stall is asserted, so o_stall follows that condition
//  synchronous active-low reset clears only the valid bits
module gradient_noise_2d import gn2_pkg::*; #(
    parameter int FRAC_BITS  = 16,
    parameter int INT_BITS   = 16,
    parameter int PHASE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_x_coord,
    input  logic [31:0]        i_y_coord,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_noise_value
);

    localparam int          LAT   = 13;
    localparam logic [31:0] IMASK = (32'd1 << INT_BITS) - 32'd1;

    // pipeline advance, shared by every stage
    logic w_en;

    // valid bits, one per stage
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    // input stage: lattice cell and fraction
    logic [31:0]          r_ix, r_iy;
    logic [FRAC_BITS-1:0] r_fx, r_fy;

    logic [31:0]               w_ix1, w_iy1;
    logic signed [FRAC_BITS:0] w_dx0, w_dx1, w_dy0, w_dy1;
    t_dot                      w_n00, w_n10, w_n01, w_n11;
    t_wt                       w_sx, w_sy;

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_comb begin
        n_vld = r_vld;
        if (w_en) begin
            n_vld = {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // truncation equals floor since coordinates are unsigned
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ix <= (i_x_coord >> FRAC_BITS) & IMASK;
            r_iy <= (i_y_coord >> FRAC_BITS) & IMASK;
            r_fx <= i_x_coord[FRAC_BITS-1:0];
            r_fy <= i_y_coord[FRAC_BITS-1:0];
        end
    end

    // upper corner: no wrap at the lattice width
    assign w_ix1 = r_ix + 32'd1;
    assign w_iy1 = r_iy + 32'd1;

    // offsets from lower and upper corners in q(FRAC_BITS)
    assign w_dx0 = {1'b0, r_fx};
    assign w_dx1 = {1'b1, r_fx};
    assign w_dy0 = {1'b0, r_fy};
    assign w_dy1 = {1'b1, r_fy};

    gn2_corner #(.FRAC_BITS(FRAC_BITS), .PHASE_BITS(PHASE_BITS)) u_c00 (
        .i_clk(i_clk), .i_en(w_en), .i_cx(r_ix), .i_cy(r_iy),
        .i_dx(w_dx0), .i_dy(w_dy0), .o_dot(w_n00)
    );
    gn2_corner #(.FRAC_BITS(FRAC_BITS), .PHASE_BITS(PHASE_BITS)) u_c10 (
        .i_clk(i_clk), .i_en(w_en), .i_cx(w_ix1), .i_cy(r_iy),
        .i_dx(w_dx1), .i_dy(w_dy0), .o_dot(w_n10)
    );
    gn2_corner #(.FRAC_BITS(FRAC_BITS), .PHASE_BITS(PHASE_BITS)) u_c01 (
        .i_clk(i_clk), .i_en(w_en), .i_cx(r_ix), .i_cy(w_iy1),
        .i_dx(w_dx0), .i_dy(w_dy1), .o_dot(w_n01)
    );
    gn2_corner #(.FRAC_BITS(FRAC_BITS), .PHASE_BITS(PHASE_BITS)) u_c11 (
        .i_clk(i_clk), .i_en(w_en), .i_cx(w_ix1), .i_cy(w_iy1),
        .i_dx(w_dx1), .i_dy(w_dy1), .o_dot(w_n11)
    );

    // weights run beside the corner lanes with matching latency
    gn2_weight #(.FRAC_BITS(FRAC_BITS)) u_wx (
        .i_clk(i_clk), .i_en(w_en), .i_frac(r_fx), .o_wt(w_sx)
    );
    gn2_weight #(.FRAC_BITS(FRAC_BITS)) u_wy (
        .i_clk(i_clk), .i_en(w_en), .i_frac(r_fy), .o_wt(w_sy)
    );

    gn2_blend u_blend (
        .i_clk(i_clk), .i_en(w_en),
        .i_n00(w_n00), .i_n10(w_n10), .i_n01(w_n01), .i_n11(w_n11),
        .i_sx(w_sx), .i_sy(w_sy), .o_noise(o_noise_value)
    );

endmodule

// ===== design/gn2_sine.sv =====
// four-stage sine of a 16-bit turn, signed q15 result
module gn2_sine import gn2_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_turn,
    output logic signed [15:0] o_val
);

    logic [14:0] w_z;
    logic [29:0] w_zz;
    logic [26:0] w_m1;
    logic [30:0] w_m2;
    logic [30:0] w_m3;
    logic [16:0] w_s;
    logic [14:0] w_sat;

    logic [14:0] r_z1, r_z2, r_z3;
    logic [14:0] r_zsq1, r_zsq2;
    logic        r_neg1, r_neg2, r_neg3;
    logic [15:0] r_p1;
    logic [15:0] r_p2;
    logic signed [15:0] r_val;

    // mirror odd quadrants
    assign w_z  = i_turn[14] ? 15'(QTR_Z - {1'b0, i_turn[13:0]}) : {1'b0, i_turn[13:0]};
    assign w_zz = 30'(w_z) * 30'(w_z);
    assign w_m1 = 27'(r_zsq1) * 27'(SIN_B);
    assign w_m2 = 31'(r_zsq2) * 31'(r_p1);
    assign w_m3 = 31'(r_z3) * 31'(r_p2);
    assign w_s  = w_m3[30:14];
    assign w_sat = (w_s > SIN_MAX) ? 15'h7fff : w_s[14:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1   <= w_z;
            r_zsq1 <= w_zz[28:14];
            r_neg1 <= i_turn[15];

            r_p1   <= SIN_A - 16'(w_m1[26:14]);
            r_zsq2 <= r_zsq1;
            r_z2   <= r_z1;
            r_neg2 <= r_neg1;

            r_p2   <= SIN_C - 16'(w_m2[30:14]);
            r_z3   <= r_z2;
            r_neg3 <= r_neg2;

            r_val  <= r_neg3 ? -$signed({1'b0, w_sat}) : $signed({1'b0, w_sat});
        end
    end

    assign o_val = r_val;

endmodule

// ===== design/gn2_corner.sv =====
// per-corner lane: hash, sine/cosine gradient and dot product, eight stages
module gn2_corner import gn2_pkg::*; #(
    parameter int FRAC_BITS  = 16,
    parameter int PHASE_BITS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [31:0]               i_cx,
    input  logic [31:0]               i_cy,
    input  logic signed [FRAC_BITS:0] i_dx,
    input  logic signed [FRAC_BITS:0] i_dy,
    output t_dot                      o_dot
);

    localparam int PW = FRAC_BITS + 18;
    localparam int DLY = 7;

    logic [31:0] r_a, r_ab, r_cy, r_b, r_h;
    logic signed [FRAC_BITS:0] r_dx [DLY];
    logic signed [FRAC_BITS:0] r_dy [DLY];
    t_dot r_dot;

    logic [15:0]          w_tsin, w_tcos;
    logic signed [15:0]   w_gs, w_gc;
    logic signed [PW-1:0] w_pa, w_pb, w_sum;

    // phase from top hash bits
    assign w_tsin = {r_h[31 -: PHASE_BITS], {(16 - PHASE_BITS){1'b0}}};
    assign w_tcos = w_tsin + TURN_QTR;

    gn2_sine u_sin (.i_clk(i_clk), .i_en(i_en), .i_turn(w_tsin), .o_val(w_gs));
    gn2_sine u_cos (.i_clk(i_clk), .i_en(i_en), .i_turn(w_tcos), .o_val(w_gc));

    assign w_pa  = PW'(r_dx[DLY-1]) * PW'(w_gs);
    assign w_pb  = PW'(r_dy[DLY-1]) * PW'(w_gc);
    assign w_sum = w_pa + w_pb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a  <= 32'(i_cx * HASH_K0);
            r_cy <= i_cy;
            r_b  <= 32'((r_cy ^ rotl16(r_a)) * HASH_K1);
            r_ab <= r_a;
            r_h  <= 32'((r_ab ^ rotl16(r_b)) * HASH_K2);
            r_dx[0] <= i_dx;
            r_dy[0] <= i_dy;
            for (int k = 1; k < DLY; k++) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
            end
            r_dot <= t_dot'(w_sum >>> FRAC_BITS);
        end
    end

    assign o_dot = r_dot;

endmodule

// ===== design/gn2_weight.sv =====
// smoothstep weight of a fraction, delayed to line up with the corner lanes
module gn2_weight import gn2_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS-1:0] i_frac,
    output t_wt                  o_wt
);

    // the square stage plus this delay match the eight-stage corner lanes
    localparam int DLY = 7;

    logic [15:0] w_w;
    logic [31:0] w_ww;
    logic [17:0] w_f;
    logic [33:0] w_p;

    logic [15:0] r_sq, r_w;
    t_wt         r_dly [DLY];

    generate
        if (FRAC_BITS >= 16) begin : g_trunc
            assign w_w = i_frac[FRAC_BITS-1 -: 16];
        end else begin : g_widen
            assign w_w = {i_frac, {(16 - FRAC_BITS){1'b0}}};
        end
    endgenerate

    assign w_ww = 32'(w_w) * 32'(w_w);
    assign w_f  = WT_THREE - {1'b0, r_w, 1'b0};
    assign w_p  = 34'(r_sq) * 34'(w_f);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= w_ww[31:16];
            r_w  <= w_w;
            r_dly[0] <= w_p[33:16];
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_wt = r_dly[DLY-1];

endmodule

// ===== design/gn2_blend.sv =====
// bilinear smoothstep blend of the four corner values, four stages
module gn2_blend import gn2_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_dot               i_n00,
    input  t_dot               i_n10,
    input  t_dot               i_n01,
    input  t_dot               i_n11,
    input  t_wt                i_sx,
    input  t_wt                i_sy,
    output logic signed [15:0] o_noise
);

    logic signed [18:0] w_d0, w_d1;
    logic signed [20:0] w_e;
    logic signed [23:0] w_v;

    logic signed [37:0] r_m0, r_m1;
    t_dot               r_n00, r_n01;
    t_wt                r_sy1, r_sy2;
    logic signed [19:0] r_r0, r_r1, r_r0b;
    logic signed [39:0] r_m2;
    logic signed [15:0] r_out;

    assign w_d0 = 19'(i_n10) - 19'(i_n00);
    assign w_d1 = 19'(i_n11) - 19'(i_n01);
    assign w_e  = 21'(r_r1) - 21'(r_r0);
    assign w_v  = 24'(r_r0b) + 24'(r_m2 >>> 16);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0  <= 38'(w_d0) * 38'($signed({1'b0, i_sx}));
            r_m1  <= 38'(w_d1) * 38'($signed({1'b0, i_sx}));
            r_n00 <= i_n00;
            r_n01 <= i_n01;
            r_sy1 <= i_sy;

            r_r0  <= 20'(r_n00) + 20'(r_m0 >>> 16);
            r_r1  <= 20'(r_n01) + 20'(r_m1 >>> 16);
            r_sy2 <= r_sy1;

            r_m2  <= 40'(w_e) * 40'($signed({1'b0, r_sy2}));
            r_r0b <= r_r0;

            if (w_v > 24'sd32767) begin
                r_out <= 16'sh7fff;
            end else if (w_v < -24'sd32768) begin
                r_out <= 16'sh8000;
            end else begin
                r_out <= w_v[15:0];
            end
        end
    end

    assign o_noise = r_out;

endmodule

// ===== design/gn2_chk.sv =====
// port-level checker for the gradient noise pipeline, bound to the top level
module gn2_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_noise_value
);

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // input side halts only when a finished item is blocked at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("o_stall without a blocked output item");

    // a blocked output item is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_noise_value)))
        else $error("output item changed while stalled");

    // handshake lines are always known out of reset
    a_ctl_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({i_valid, o_stall, o_valid, i_stall}))
        else $error("handshake line unknown");

    // an offered output item carries known data
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_noise_value))
        else $error("output item has unknown bits");

endmodule

bind gradient_noise_2d gn2_chk u_gn2_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_noise_value(o_noise_value)
);
